/* src/bgsl_pkg.sv */
// Shared types and constants for the BMP grayscale stream loader.
package bgsl_pkg;

  // Parser phase of the byte front end.
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXEL,
    PH_PAD,
    PH_IDLE
  } phase_t;

  // Steps of the image size product sequencer.
  typedef enum logic [2:0] {
    MS_IDLE,
    MS_PAD,
    MS_LO,
    MS_HI,
    MS_SUM
  } mul_step_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Reject codes; the field reads as zero on accept and pixel results.
  localparam logic [2:0] ERR_MAGIC   = 3'd0;
  localparam logic [2:0] ERR_HSIZE   = 3'd1;
  localparam logic [2:0] ERR_DEPTH   = 3'd2;
  localparam logic [2:0] ERR_COMP    = 3'd3;
  localparam logic [2:0] ERR_PLANES  = 3'd4;
  localparam logic [2:0] ERR_SIZE    = 3'd5;
  localparam logic [2:0] ERR_DIM     = 3'd6;
  localparam logic [2:0] ERR_CLEAR   = 3'd0;

  // Byte positions in the combined file and info header.
  localparam logic [5:0] POS_MAGIC0  = 6'd0;
  localparam logic [5:0] POS_MAGIC1  = 6'd1;
  localparam logic [5:0] POS_HSIZE   = 6'd14;
  localparam logic [5:0] POS_WIDTH   = 6'd18;
  localparam logic [5:0] POS_HEIGHT  = 6'd22;
  localparam logic [5:0] POS_PLANES  = 6'd26;
  localparam logic [5:0] POS_DEPTH   = 6'd28;
  localparam logic [5:0] POS_COMP    = 6'd30;
  localparam logic [5:0] POS_ISIZE   = 6'd34;
  localparam logic [5:0] POS_LAST    = 6'd53;

  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [31:0] INFO_HDR_LEN = 32'd40;
  localparam logic [15:0] BITS_24      = 16'd24;
  localparam logic [15:0] ONE_PLANE    = 16'd1;

  // Luma weights in Q16: 0.299, 0.587 and 0.114.
  localparam logic [14:0] W_RED   = 15'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [12:0] W_BLUE  = 13'd7471;

  localparam int COORD_W = 13;
  localparam int GRAY_W  = 16;
  typedef logic [COORD_W-1:0] coord_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    kind_t      kind;
    logic [2:0] err;
    coord_t     row;
    coord_t     col;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } op_t;

endpackage

/* src/bmp24_grayscale_stream_loader_unit.sv */
// Top level of the BMP 24-bit grayscale stream loader.
//
// The block takes one file byte per transfer and sustains one byte per clock
// while the queue has room. The 54 header bytes are parsed little-endian. The
// edge that takes the last header byte also queues an accept result (height in
// row, width in col) or a reject result with its error code. Pixel bytes then
// come in B, G, R order and every third byte gives one Q8 luma result with
// the top-down row and the column; row padding is dropped and bytes after a
// reject or the final pixel are ignored until a transfer with the start flag
// set, which restarts parsing at any time. The image size check uses a
// 32x16 multiplier twice in the pad, low, high and sum steps after the last
// height byte, which the remaining header bytes always cover. Results leave
// through a four-entry queue, a product stage and an output register, so a
// stalled output does not stop input until the queue fills.
module bmp24_grayscale_stream_loader_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic [0:0]  in_tuser,   // [0] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [2:0] error_code, [15:3] row, [28:16] col,
                                  // [44:29] gray, [47:45] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);

  logic                        q_full;
  logic                        q_empty;
  logic                        push;
  logic                        pop;
  bgsl_pkg::op_t               push_op;
  bgsl_pkg::op_t               head_op;
  bgsl_pkg::kind_t             res_kind;
  logic [2:0]                  res_err;
  bgsl_pkg::coord_t            res_row;
  bgsl_pkg::coord_t            res_col;
  logic [bgsl_pkg::GRAY_W-1:0] res_gray;

  bgsl_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_first (in_tuser[0]),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  bgsl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .head_op (head_op)
  );

  bgsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_op   (head_op),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (res_kind),
    .out_err   (res_err),
    .out_row   (res_row),
    .out_col   (res_col),
    .out_gray  (res_gray),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, res_gray, res_col, res_row, res_err};
  assign out_tuser = res_kind;

endmodule

/* src/bgsl_front.sv */
// Byte front end: header parse, header checks, pixel assembly and row bookkeeping.
module bgsl_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_first,
  input  logic             q_full,
  output logic             push,
  output bgsl_pkg::op_t    push_op
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  localparam logic [1:0] BIP_BLUE  = 2'd0;
  localparam logic [1:0] BIP_GREEN = 2'd1;
  localparam logic [1:0] BIP_RED   = 2'd2;

  bgsl_pkg::phase_t    phase_r, phase_nxt, cur_phase;
  bgsl_pkg::mul_step_t mstep_r, mstep_nxt;

  logic [5:0]       pos_r, pos_nxt, cur_pos;
  logic [1:0]       bip_r, bip_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [7:0]       blue_r, blue_nxt;
  logic [7:0]       green_r, green_nxt;

  logic [7:0]  magic0_r, magic0_nxt;
  logic [7:0]  magic1_r, magic1_nxt;
  logic [31:0] hsize_r, hsize_nxt;
  logic [31:0] fw_r, fw_nxt;
  logic [31:0] fh_r, fh_nxt;
  logic [15:0] planes_r, planes_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] comp_r, comp_nxt;
  logic [31:0] isize_r, isize_nxt;

  logic [33:0] padded_r;
  logic [47:0] plo_r;
  logic [47:0] phi_r;
  logic [63:0] prod_r;
  logic [33:0] row_sum;

  logic       acc;
  logic       hdr_ok;
  logic [2:0] hdr_code;
  logic       mismatch;
  logic       col_end;
  logic       row_end;
  logic       last_px;
  logic [DIM_W-1:0] row_out;
  logic [1:0] off;

  assign in_ready  = !q_full;
  assign acc       = in_valid && !q_full;
  assign cur_phase = in_first ? bgsl_pkg::PH_HEADER : phase_r;
  assign cur_pos   = in_first ? bgsl_pkg::POS_MAGIC0 : pos_r;

  assign col_end = ({1'b0, col_r} + 1'b1) == {1'b0, width_r};
  assign row_end = ({1'b0, row_r} + 1'b1) == {1'b0, height_r};
  assign last_px = col_end && row_end;
  assign row_out = height_r - row_r - 1'b1;

  // A zero height makes the product zero, so only a zero size field matches.
  assign mismatch = (fh_r == 32'd0) ? (isize_r != 32'd0)
                  : ((padded_r[33:32] != 2'b00) || (prod_r != {32'd0, isize_r}));

  always_comb begin
    hdr_ok   = 1'b0;
    hdr_code = bgsl_pkg::ERR_CLEAR;
    priority if (magic0_r != bgsl_pkg::MAGIC_B || magic1_r != bgsl_pkg::MAGIC_M) begin
      hdr_code = bgsl_pkg::ERR_MAGIC;
    end else if (hsize_r != bgsl_pkg::INFO_HDR_LEN) begin
      hdr_code = bgsl_pkg::ERR_HSIZE;
    end else if (depth_r != bgsl_pkg::BITS_24) begin
      hdr_code = bgsl_pkg::ERR_DEPTH;
    end else if (comp_r != 32'd0) begin
      hdr_code = bgsl_pkg::ERR_COMP;
    end else if (planes_r != bgsl_pkg::ONE_PLANE) begin
      hdr_code = bgsl_pkg::ERR_PLANES;
    end else if (mismatch) begin
      hdr_code = bgsl_pkg::ERR_SIZE;
    end else if (fw_r == 32'd0 || fw_r > 32'(MAX_DIM) ||
                 fh_r == 32'd0 || fh_r > 32'(MAX_DIM)) begin
      hdr_code = bgsl_pkg::ERR_DIM;
    end else begin
      hdr_ok = 1'b1;
    end
  end

  // Parser phase.
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (cur_phase)
        bgsl_pkg::PH_HEADER: begin
          if (cur_pos == bgsl_pkg::POS_LAST) begin
            phase_nxt = hdr_ok ? bgsl_pkg::PH_PIXEL : bgsl_pkg::PH_IDLE;
          end else begin
            phase_nxt = bgsl_pkg::PH_HEADER;
          end
        end
        bgsl_pkg::PH_PIXEL: begin
          if (bip_r == BIP_RED && last_px) begin
            phase_nxt = bgsl_pkg::PH_IDLE;
          end else if (bip_r == BIP_RED && col_end && width_r[1:0] != 2'd0) begin
            phase_nxt = bgsl_pkg::PH_PAD;
          end else begin
            phase_nxt = bgsl_pkg::PH_PIXEL;
          end
        end
        bgsl_pkg::PH_PAD: begin
          phase_nxt = (pad_r == 2'd1) ? bgsl_pkg::PH_PIXEL : bgsl_pkg::PH_PAD;
        end
        default: begin
          phase_nxt = bgsl_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Header fields, pixel assembly and counters.
  always_comb begin
    pos_nxt    = pos_r;
    bip_nxt    = bip_r;
    pad_nxt    = pad_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    magic0_nxt = magic0_r;
    magic1_nxt = magic1_r;
    hsize_nxt  = hsize_r;
    fw_nxt     = fw_r;
    fh_nxt     = fh_r;
    planes_nxt = planes_r;
    depth_nxt  = depth_r;
    comp_nxt   = comp_r;
    isize_nxt  = isize_r;
    off        = 2'd0;
    push       = 1'b0;
    push_op    = '0;
    if (acc) begin
      unique case (cur_phase)
        bgsl_pkg::PH_HEADER: begin
          pos_nxt = (cur_pos == bgsl_pkg::POS_LAST) ? 6'd0 : cur_pos + 6'd1;
          if (cur_pos == bgsl_pkg::POS_MAGIC0) begin
            magic0_nxt = in_byte;
          end else if (cur_pos == bgsl_pkg::POS_MAGIC1) begin
            magic1_nxt = in_byte;
          end else if (cur_pos >= bgsl_pkg::POS_HSIZE && cur_pos < bgsl_pkg::POS_WIDTH) begin
            off = cur_pos[1:0] - bgsl_pkg::POS_HSIZE[1:0];
            if (off == 2'd0) hsize_nxt = 32'(in_byte);
            else hsize_nxt[{off, 3'b000} +: 8] = in_byte;
          end else if (cur_pos >= bgsl_pkg::POS_WIDTH && cur_pos < bgsl_pkg::POS_HEIGHT) begin
            off = cur_pos[1:0] - bgsl_pkg::POS_WIDTH[1:0];
            if (off == 2'd0) fw_nxt = 32'(in_byte);
            else fw_nxt[{off, 3'b000} +: 8] = in_byte;
          end else if (cur_pos >= bgsl_pkg::POS_HEIGHT && cur_pos < bgsl_pkg::POS_PLANES) begin
            off = cur_pos[1:0] - bgsl_pkg::POS_HEIGHT[1:0];
            if (off == 2'd0) fh_nxt = 32'(in_byte);
            else fh_nxt[{off, 3'b000} +: 8] = in_byte;
          end else if (cur_pos >= bgsl_pkg::POS_PLANES && cur_pos < bgsl_pkg::POS_DEPTH) begin
            off = cur_pos[1:0] - bgsl_pkg::POS_PLANES[1:0];
            if (off == 2'd0) planes_nxt = 16'(in_byte);
            else planes_nxt[{off[0], 3'b000} +: 8] = in_byte;
          end else if (cur_pos >= bgsl_pkg::POS_DEPTH && cur_pos < bgsl_pkg::POS_COMP) begin
            off = cur_pos[1:0] - bgsl_pkg::POS_DEPTH[1:0];
            if (off == 2'd0) depth_nxt = 16'(in_byte);
            else depth_nxt[{off[0], 3'b000} +: 8] = in_byte;
          end else if (cur_pos >= bgsl_pkg::POS_COMP && cur_pos < bgsl_pkg::POS_ISIZE) begin
            off = cur_pos[1:0] - bgsl_pkg::POS_COMP[1:0];
            if (off == 2'd0) comp_nxt = 32'(in_byte);
            else comp_nxt[{off, 3'b000} +: 8] = in_byte;
          end else if (cur_pos >= bgsl_pkg::POS_ISIZE && cur_pos < 6'd38) begin
            off = cur_pos[1:0] - bgsl_pkg::POS_ISIZE[1:0];
            if (off == 2'd0) isize_nxt = 32'(in_byte);
            else isize_nxt[{off, 3'b000} +: 8] = in_byte;
          end
          if (cur_pos == bgsl_pkg::POS_LAST) begin
            push = 1'b1;
            if (hdr_ok) begin
              push_op.kind = bgsl_pkg::KIND_ACCEPT;
              push_op.row  = bgsl_pkg::coord_t'(fh_r);
              push_op.col  = bgsl_pkg::coord_t'(fw_r);
              width_nxt    = DIM_W'(fw_r);
              height_nxt   = DIM_W'(fh_r);
              col_nxt      = '0;
              row_nxt      = '0;
              bip_nxt      = BIP_BLUE;
              pad_nxt      = 2'd0;
            end else begin
              push_op.kind = bgsl_pkg::KIND_REJECT;
              push_op.err  = hdr_code;
            end
          end
        end
        bgsl_pkg::PH_PIXEL: begin
          if (bip_r == BIP_BLUE) begin
            blue_nxt = in_byte;
            bip_nxt  = BIP_GREEN;
          end else if (bip_r == BIP_GREEN) begin
            green_nxt = in_byte;
            bip_nxt   = BIP_RED;
          end else begin
            bip_nxt       = BIP_BLUE;
            push          = 1'b1;
            push_op.kind  = bgsl_pkg::KIND_PIXEL;
            push_op.row   = bgsl_pkg::coord_t'(row_out);
            push_op.col   = bgsl_pkg::coord_t'(col_r);
            push_op.blue  = blue_r;
            push_op.green = green_r;
            push_op.red   = in_byte;
            push_op.last  = last_px;
            col_nxt       = col_r + 1'b1;
            if (!last_px && col_end) begin
              pad_nxt = width_r[1:0];
              if (width_r[1:0] == 2'd0) begin
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
              end
            end
          end
        end
        bgsl_pkg::PH_PAD: begin
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The size product runs while the header bytes after the height arrive.
  always_comb begin
    mstep_nxt = mstep_r;
    unique case (mstep_r)
      bgsl_pkg::MS_IDLE: mstep_nxt = bgsl_pkg::MS_IDLE;
      bgsl_pkg::MS_PAD:  mstep_nxt = bgsl_pkg::MS_LO;
      bgsl_pkg::MS_LO:   mstep_nxt = bgsl_pkg::MS_HI;
      bgsl_pkg::MS_HI:   mstep_nxt = bgsl_pkg::MS_SUM;
      default:           mstep_nxt = bgsl_pkg::MS_IDLE;
    endcase
    if (acc && cur_phase == bgsl_pkg::PH_HEADER && cur_pos == (bgsl_pkg::POS_PLANES - 6'd1)) begin
      mstep_nxt = bgsl_pkg::MS_PAD;
    end
  end

  assign row_sum = {1'b0, fw_r, 1'b0} + {2'b00, fw_r} + 34'd3;

  always_ff @(posedge clk) begin
    unique case (mstep_r)
      bgsl_pkg::MS_PAD: padded_r <= {row_sum[33:2], 2'b00};
      bgsl_pkg::MS_LO:  plo_r    <= padded_r[31:0] * fh_r[15:0];
      bgsl_pkg::MS_HI:  phi_r    <= padded_r[31:0] * fh_r[31:16];
      bgsl_pkg::MS_SUM: prod_r   <= 64'(plo_r) + {phi_r, 16'd0};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bgsl_pkg::PH_HEADER;
      mstep_r  <= bgsl_pkg::MS_IDLE;
      pos_r    <= 6'd0;
      bip_r    <= BIP_BLUE;
      pad_r    <= 2'd0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      mstep_r  <= mstep_nxt;
      pos_r    <= pos_nxt;
      bip_r    <= bip_nxt;
      pad_r    <= pad_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blue_r   <= blue_nxt;
    green_r  <= green_nxt;
    magic0_r <= magic0_nxt;
    magic1_r <= magic1_nxt;
    hsize_r  <= hsize_nxt;
    fw_r     <= fw_nxt;
    fh_r     <= fh_nxt;
    planes_r <= planes_nxt;
    depth_r  <= depth_nxt;
    comp_r   <= comp_nxt;
    isize_r  <= isize_nxt;
  end

endmodule

/* src/bgsl_queue.sv */
// Short queue of classified items between the front end and the back end.
module bgsl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bgsl_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output bgsl_pkg::op_t head_op
);

  bgsl_pkg::op_t mem [bgsl_pkg::QUEUE_DEPTH];

  logic [bgsl_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bgsl_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bgsl_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full    = count_r == (bgsl_pkg::QPTR_W + 1)'(bgsl_pkg::QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/bgsl_back.sv */
// Back end: luma products, weighted sum and the registered result stage.
module bgsl_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  bgsl_pkg::op_t                      head_op,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bgsl_pkg::kind_t                    out_kind,
  output logic [2:0]                         out_err,
  output bgsl_pkg::coord_t                   out_row,
  output bgsl_pkg::coord_t                   out_col,
  output logic [bgsl_pkg::GRAY_W-1:0]        out_gray,
  output logic                               out_last
);

  logic          s1_valid_r, s1_valid_nxt;
  bgsl_pkg::op_t s1_op_r;
  logic [22:0]   pr_r;
  logic [23:0]   pg_r;
  logic [20:0]   pb_r;
  logic [23:0]   wsum;

  logic                        out_valid_r, out_valid_nxt;
  bgsl_pkg::kind_t             out_kind_r;
  logic [2:0]                  out_err_r;
  bgsl_pkg::coord_t            out_row_r;
  bgsl_pkg::coord_t            out_col_r;
  logic [bgsl_pkg::GRAY_W-1:0] out_gray_r;
  logic                        out_last_r;

  logic out_load;
  logic s1_load;

  // The result register takes a new value whenever it is empty or being drained.
  assign out_load = !out_valid_r || out_ready;
  assign s1_load  = out_load || !s1_valid_r;
  assign pop      = s1_load && !q_empty;
  assign wsum     = 24'(pr_r) + pg_r + 24'(pb_r);

  always_comb begin
    s1_valid_nxt  = s1_load ? !q_empty : s1_valid_r;
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r <= head_op;
      pr_r    <= head_op.red * bgsl_pkg::W_RED;
      pg_r    <= head_op.green * bgsl_pkg::W_GREEN;
      pb_r    <= head_op.blue * bgsl_pkg::W_BLUE;
    end
    if (out_load) begin
      out_kind_r <= s1_op_r.kind;
      out_err_r  <= s1_op_r.err;
      out_row_r  <= s1_op_r.row;
      out_col_r  <= s1_op_r.col;
      out_gray_r <= wsum[23:8];
      out_last_r <= s1_op_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_err   = out_err_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_gray  = out_gray_r;
  assign out_last  = out_last_r;

endmodule

/* test/bgsl_checker.sv */
// Checker for the BMP grayscale stream loader: predicts results from input transfers and compares.
module bgsl_checker #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic [0:0]  in_tuser,   // [0] first_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [2:0] error_code, [15:3] row, [28:16] col, [44:29] gray
  input  logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        out_tlast,
  output int          n_errors,
  output int          n_pending,
  output int          n_pixels,
  output int          n_accepts,
  output int          n_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bgsl_pkg::kind_t             kind;
    logic [2:0]                  err;
    bgsl_pkg::coord_t            row;
    bgsl_pkg::coord_t            col;
    logic [bgsl_pkg::GRAY_W-1:0] gray;
    logic                        last;
  } luma_res_t;

  bgsl_pkg::phase_t phase;
  int unsigned      hdr_pos;
  logic [7:0]       hdr_bytes [54];
  int unsigned      img_w, img_h, col_cnt, row_cnt, pad_cnt, pix_byte;
  logic [7:0]       blue_q, green_q;
  luma_res_t        luma_q [$];
  int               errs, pix_cnt, acc_cnt, rej_cnt;

  function automatic logic [31:0] hdr_word(input int start, input int nbytes);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < nbytes; k++) w[8*k +: 8] = hdr_bytes[start + k];
    return w;
  endfunction

  // Returns 1 when every header check passes; otherwise code holds the first failing check.
  function automatic logic header_ok(output logic [2:0] code);
    logic [31:0] hsize, wid, hgt, comp, isize;
    logic [15:0] planes, depth;
    logic [63:0] row_len;
    logic        size_bad;
    hsize  = hdr_word(bgsl_pkg::POS_HSIZE, 4);
    wid    = hdr_word(bgsl_pkg::POS_WIDTH, 4);
    hgt    = hdr_word(bgsl_pkg::POS_HEIGHT, 4);
    planes = 16'(hdr_word(bgsl_pkg::POS_PLANES, 2));
    depth  = 16'(hdr_word(bgsl_pkg::POS_DEPTH, 2));
    comp   = hdr_word(bgsl_pkg::POS_COMP, 4);
    isize  = hdr_word(bgsl_pkg::POS_ISIZE, 4);
    // The size product is exact; it must not wrap at 32 bits.
    row_len = ((64'(wid) * 3 + 3) / 4) * 4;
    if (hgt == 0) size_bad = (isize != 0);
    else if (row_len > 64'hFFFF_FFFF) size_bad = 1'b1;
    else size_bad = (row_len * 64'(hgt) != 64'(isize));
    code = bgsl_pkg::ERR_CLEAR;
    header_ok = 1'b0;
    if (hdr_bytes[bgsl_pkg::POS_MAGIC0] != bgsl_pkg::MAGIC_B ||
        hdr_bytes[bgsl_pkg::POS_MAGIC1] != bgsl_pkg::MAGIC_M) code = bgsl_pkg::ERR_MAGIC;
    else if (hsize != bgsl_pkg::INFO_HDR_LEN) code = bgsl_pkg::ERR_HSIZE;
    else if (depth != bgsl_pkg::BITS_24) code = bgsl_pkg::ERR_DEPTH;
    else if (comp != 0) code = bgsl_pkg::ERR_COMP;
    else if (planes != bgsl_pkg::ONE_PLANE) code = bgsl_pkg::ERR_PLANES;
    else if (size_bad) code = bgsl_pkg::ERR_SIZE;
    else if (wid < 1 || wid > MAX_DIM || hgt < 1 || hgt > MAX_DIM) code = bgsl_pkg::ERR_DIM;
    else header_ok = 1'b1;
  endfunction

  function automatic void next_row();
    col_cnt = 0;
    row_cnt++;
    phase = (row_cnt >= img_h) ? bgsl_pkg::PH_IDLE : bgsl_pkg::PH_PIXEL;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic mark);
    luma_res_t   r;
    logic [2:0]  code;
    logic [31:0] luma;
    if (mark) begin
      phase = bgsl_pkg::PH_HEADER;
      hdr_pos = 0;
    end
    r = '0;
    case (phase)
      bgsl_pkg::PH_HEADER: begin
        hdr_bytes[hdr_pos] = b;
        if (hdr_pos < bgsl_pkg::POS_LAST) begin
          hdr_pos++;
        end else begin
          hdr_pos = 0;
          if (header_ok(code)) begin
            img_w    = hdr_word(bgsl_pkg::POS_WIDTH, 4);
            img_h    = hdr_word(bgsl_pkg::POS_HEIGHT, 4);
            col_cnt  = 0;
            row_cnt  = 0;
            pix_byte = 0;
            pad_cnt  = 0;
            phase    = bgsl_pkg::PH_PIXEL;
            r.kind   = bgsl_pkg::KIND_ACCEPT;
            r.row    = bgsl_pkg::coord_t'(img_h);
            r.col    = bgsl_pkg::coord_t'(img_w);
          end else begin
            phase  = bgsl_pkg::PH_IDLE;
            r.kind = bgsl_pkg::KIND_REJECT;
            r.err  = code;
          end
          luma_q.push_back(r);
        end
      end
      bgsl_pkg::PH_PIXEL: begin
        // Pixel bytes arrive blue, green, red.
        if (pix_byte == 0) begin
          blue_q = b;
          pix_byte = 1;
        end else if (pix_byte == 1) begin
          green_q = b;
          pix_byte = 2;
        end else begin
          pix_byte = 0;
          luma = 32'(bgsl_pkg::W_RED) * b + 32'(bgsl_pkg::W_GREEN) * green_q +
                 32'(bgsl_pkg::W_BLUE) * blue_q;
          r.kind = bgsl_pkg::KIND_PIXEL;
          r.row  = bgsl_pkg::coord_t'(img_h - 1 - row_cnt);
          r.col  = bgsl_pkg::coord_t'(col_cnt);
          r.gray = luma[23:8];
          r.last = (row_cnt + 1 == img_h) && (col_cnt + 1 == img_w);
          luma_q.push_back(r);
          col_cnt++;
          if (r.last) begin
            phase = bgsl_pkg::PH_IDLE;
          end else if (col_cnt >= img_w) begin
            // A row of 3*w bytes needs w mod 4 padding bytes.
            pad_cnt = img_w % 4;
            if (pad_cnt == 0) next_row();
            else phase = bgsl_pkg::PH_PAD;
          end
        end
      end
      bgsl_pkg::PH_PAD: begin
        pad_cnt--;
        if (pad_cnt == 0) next_row();
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  task automatic check_result();
    luma_res_t e;
    if (luma_q.size() == 0) begin
      $error("result with nothing expected: kind %0d row %0d col %0d",
             out_tuser, out_tdata[15:3], out_tdata[28:16]);
      errs++;
    end else begin
      e = luma_q.pop_front();
      case (e.kind)
        bgsl_pkg::KIND_PIXEL:  pix_cnt++;
        bgsl_pkg::KIND_ACCEPT: acc_cnt++;
        default:               rej_cnt++;
      endcase
      check_field("kind", e.kind, out_tuser);
      check_field("error_code", e.err, out_tdata[2:0]);
      check_field("row", e.row, out_tdata[15:3]);
      check_field("col", e.col, out_tdata[28:16]);
      check_field("gray", e.gray, out_tdata[44:29]);
      check_field("last", e.last, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase    = bgsl_pkg::PH_HEADER;
      hdr_pos  = 0;
      img_w    = 0;
      img_h    = 0;
      col_cnt  = 0;
      row_cnt  = 0;
      pad_cnt  = 0;
      pix_byte = 0;
      blue_q   = '0;
      green_q  = '0;
      for (int k = 0; k < 54; k++) hdr_bytes[k] = '0;
      luma_q.delete();
    end else begin
      // Predict first so that a result leaving on the same edge finds its expectation.
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) check_result();
    end
    n_errors  <= errs;
    n_pending <= luma_q.size();
    n_pixels  <= pix_cnt;
    n_accepts <= acc_cnt;
    n_rejects <= rej_cnt;
  end

  initial begin
    errs = 0;
    pix_cnt = 0;
    acc_cnt = 0;
    rej_cnt = 0;
  end

endmodule

/* test/tb.sv */
// Testbench top for the BMP grayscale stream loader: clock, reset, byte stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM     = 4096;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN       = 16;
  localparam int TOTAL_BYTES = 750;

  typedef struct {
    logic [7:0]  m0, m1;
    logic [31:0] hsize, wid, hgt, comp, isize;
    logic [15:0] planes, depth;
  } hdr_fields_t;

  // Ways a header can be spoiled.
  typedef enum int {
    BAD_MAGIC0, BAD_MAGIC1, BAD_HSIZE, BAD_DEPTH, BAD_COMP,
    BAD_PLANES, BAD_ISIZE, BAD_WIDTH, BAD_HEIGHT
  } flaw_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] file_byte
  logic [0:0]  in_tuser;   // [0] first_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [2:0] error_code, [15:3] row, [28:16] col, [44:29] gray
  logic [1:0]  out_tuser;  // [1:0] kind
  logic        out_tlast;

  int n_errors, n_pending, n_pixels, n_accepts, n_rejects;
  int n_bytes, n_files;
  bit gap_on;

  bmp24_grayscale_stream_loader_unit #(.MAX_DIM(MAX_DIM)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bgsl_checker #(.MAX_DIM(MAX_DIM)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .n_errors   (n_errors),
    .n_pending  (n_pending),
    .n_pixels   (n_pixels),
    .n_accepts  (n_accepts),
    .n_rejects  (n_rejects)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Padded pixel array size in bytes, truncated to the 32 bits of the header field.
  function automatic logic [31:0] image_bytes(input logic [31:0] wid, input logic [31:0] hgt);
    return 32'(((64'(wid) * 3 + 3) / 4) * 4 * 64'(hgt));
  endfunction

  function automatic logic [31:0] nonzero_word();
    logic [31:0] x;
    x = $urandom();
    return (x == 0) ? 32'd1 : x;
  endfunction

  function automatic hdr_fields_t good_header(input logic [31:0] wid, input logic [31:0] hgt);
    hdr_fields_t hd;
    hd.m0     = bgsl_pkg::MAGIC_B;
    hd.m1     = bgsl_pkg::MAGIC_M;
    hd.hsize  = bgsl_pkg::INFO_HDR_LEN;
    hd.wid    = wid;
    hd.hgt    = hgt;
    hd.planes = bgsl_pkg::ONE_PLANE;
    hd.depth  = bgsl_pkg::BITS_24;
    hd.comp   = '0;
    hd.isize  = image_bytes(wid, hgt);
    return hd;
  endfunction

  function automatic hdr_fields_t broken_header(input flaw_t flaw);
    hdr_fields_t hd;
    hd = good_header($urandom_range(1, 9), $urandom_range(1, 4));
    case (flaw)
      BAD_MAGIC0: hd.m0 ^= 8'($urandom_range(1, 255));
      BAD_MAGIC1: hd.m1 ^= 8'($urandom_range(1, 255));
      BAD_HSIZE:  hd.hsize ^= nonzero_word();
      BAD_DEPTH:  hd.depth ^= 16'($urandom_range(1, 65535));
      BAD_COMP:   hd.comp ^= nonzero_word();
      BAD_PLANES: hd.planes ^= 16'($urandom_range(1, 65535));
      BAD_ISIZE:  hd.isize ^= nonzero_word();
      // Out-of-range dimensions keep a consistent size, so only the dimension check trips.
      BAD_WIDTH: begin
        hd.wid = $urandom_range(0, 1) ? 32'd0 : 32'(MAX_DIM + $urandom_range(1, 5000));
        hd.isize = image_bytes(hd.wid, hd.hgt);
      end
      default: begin
        hd.hgt = $urandom_range(0, 1) ? 32'd0 : 32'(MAX_DIM + $urandom_range(1, 5000));
        hd.isize = image_bytes(hd.wid, hd.hgt);
      end
    endcase
    return hd;
  endfunction

  function automatic logic [7:0] pixel_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic mark);
    int gap;
    gap = gap_on ? pause_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= mark;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_bytes++;
  endtask

  // Sends the first n_send bytes of a 54-byte header; ignored fields carry random bytes.
  task automatic send_header(input hdr_fields_t hd, input logic mark, input int n_send);
    logic [7:0] img [54];
    for (int p = 0; p < 54; p++) img[p] = 8'($urandom);
    img[bgsl_pkg::POS_MAGIC0] = hd.m0;
    img[bgsl_pkg::POS_MAGIC1] = hd.m1;
    for (int k = 0; k < 4; k++) begin
      img[bgsl_pkg::POS_HSIZE + k]  = hd.hsize[8*k +: 8];
      img[bgsl_pkg::POS_WIDTH + k]  = hd.wid[8*k +: 8];
      img[bgsl_pkg::POS_HEIGHT + k] = hd.hgt[8*k +: 8];
      img[bgsl_pkg::POS_COMP + k]   = hd.comp[8*k +: 8];
      img[bgsl_pkg::POS_ISIZE + k]  = hd.isize[8*k +: 8];
    end
    for (int k = 0; k < 2; k++) begin
      img[bgsl_pkg::POS_PLANES + k] = hd.planes[8*k +: 8];
      img[bgsl_pkg::POS_DEPTH + k]  = hd.depth[8*k +: 8];
    end
    n_files++;
    for (int p = 0; p < n_send; p++) send_byte(img[p], mark && p == 0);
  endtask

  // A negative fill gives random pixel content.
  task automatic send_body(input int n, input int fill);
    for (int i = 0; i < n; i++) send_byte(fill >= 0 ? 8'(fill) : pixel_byte(), 1'b0);
  endtask

  task automatic send_image(input int wid, input int hgt, input int fill);
    send_header(good_header(wid, hgt), 1'b1, 54);
    send_body(int'(image_bytes(wid, hgt)), fill);
  endtask

  // Result side: random stalls, short ones mostly, with runs of steady readiness.
  initial begin : out_pacing
    int n;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      n = pause_len();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 8))
        @(posedge clk);
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    hdr_fields_t hd;
    int          pick, wid, hgt, len;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    n_bytes = 0;
    n_files = 0;
    gap_on  = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the block parses a file that has no start mark.
    send_header(good_header(2, 2), 1'b0, 54);
    send_body(int'(image_bytes(2, 2)), -1);
    // A white single pixel; bytes after the final pixel are ignored.
    send_image(1, 1, 8'hFF);
    send_body(3, -1);
    // One spoiled header for each reject code.
    send_header(broken_header($urandom_range(0, 1) ? BAD_MAGIC0 : BAD_MAGIC1), 1'b1, 54);
    for (int f = BAD_HSIZE; f <= BAD_ISIZE; f++) begin
      send_header(broken_header(flaw_t'(f)), 1'b1, 54);
    end
    send_header(broken_header($urandom_range(0, 1) ? BAD_WIDTH : BAD_HEIGHT), 1'b1, 54);
    // Size product past 32 bits.
    hd = good_header(MAX_DIM, 1);
    hd.hgt = 32'h0010_0000;
    hd.isize = image_bytes(hd.wid, hd.hgt);
    send_header(hd, 1'b1, 54);
    // Largest width, then largest height; each start mark cuts the image before it short.
    send_header(good_header(MAX_DIM, 1), 1'b1, 54);
    send_body(9, -1);
    send_header(good_header(1, MAX_DIM), 1'b1, 54);
    send_body(8, -1);

    while (n_bytes < TOTAL_BYTES) begin
      gap_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(0, 99);
        wid = (pick < 80) ? $urandom_range(1, 9) : $urandom_range(10, 24);
        hgt = (wid > 9) ? $urandom_range(1, 2) : $urandom_range(1, 4);
        send_header(good_header(wid, hgt), 1'b1, 54);
        len = int'(image_bytes(wid, hgt));
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, len - 1);
        send_body(len, -1);
        if ($urandom_range(0, 4) == 0) send_body($urandom_range(1, 6), -1);
      end else if (pick < 88) begin
        send_header(broken_header(flaw_t'($urandom_range(BAD_MAGIC0, BAD_HEIGHT))), 1'b1, 54);
        send_body($urandom_range(0, 4), -1);
      end else if (pick < 95) begin
        send_header(good_header($urandom_range(1, 9), $urandom_range(1, 4)), 1'b1,
                    $urandom_range(1, 53));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Streamed %0d bytes over %0d headers with random pauses on both channels.",
             n_bytes, n_files);
    $display("Checked %0d pixels, %0d accepted and %0d rejected headers.",
             n_pixels, n_accepts, n_rejects);
    if (n_errors == 0 && n_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
